// ===== src/wmpd_pkg.sv =====
// ----------------------------------------------------------------------------
// wmpd_pkg
// Shared types and constants for the wheel mixer and PWM drive pipeline.
// ----------------------------------------------------------------------------
package wmpd_pkg;

  localparam int NUM_WHEELS  = 4;   // wheel ports on the block
  localparam int WHEEL_COUNT = 4;   // wheels actually driven (2..4)
  localparam int DUTY_BITS   = 10;
  localparam logic [DUTY_BITS-1:0] DUTY_MAX = '1;

  localparam int VEL_W   = 16;
  localparam int CFG_DATA_W = 26;
  localparam int CFG_IDX_W  = 3;

  // wheel speed after mixing, Q.12
  localparam int SPD_W   = 22;
  // clamped speed, fits +-32767
  localparam int CLMP_W  = 16;
  // speed after reverse gain, fits +-65534
  localparam int GAIN_W  = 18;
  localparam int MAG_W   = GAIN_W - 1;
  localparam int RAW_W   = MAG_W + CFG_DATA_W;
  localparam int DUTY_SHIFT = 18;

  // mixing constants, Q.12
  localparam logic signed [13:0] K_ONE_P2   = 14'sd4915;
  localparam logic signed [13:0] K_SQRT3_2  = 14'sd3547;

  localparam logic [2:0] MODE_MECANUM = 3'd0;
  localparam logic [2:0] MODE_OMNI3   = 3'd1;
  localparam logic [2:0] MODE_OMNI4   = 3'd2;
  localparam logic [2:0] MODE_SKID    = 3'd3;
  localparam logic [2:0] MODE_DIFF    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_SCALE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_RADIUS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE_GAIN = 3'd5;

  typedef struct packed {
    logic [2:0]  drive_mode;
    logic [14:0] max_speed;
    logic [25:0] duty_scale;
    logic [14:0] wheel_radius;
    logic [14:0] dead_zone;
    logic [12:0] reverse_gain;
  } cfg_t;

  typedef struct packed {
    logic                    stop;
    logic signed [SPD_W-1:0] spd;
  } wheel_in_t;

endpackage

// ===== src/wmpd_mix.sv =====
// ----------------------------------------------------------------------------
// wmpd_mix
// Two-stage mixer: products of the velocity command, then the per-wheel sums
// rounded to Q.12 with unused wheels flagged.
// ----------------------------------------------------------------------------
module wmpd_mix (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  logic signed [wmpd_pkg::VEL_W-1:0]     vel_x,
  input  logic signed [wmpd_pkg::VEL_W-1:0]     vel_y,
  input  logic signed [wmpd_pkg::VEL_W-1:0]     yaw_rate,
  input  wmpd_pkg::cfg_t                        cfg,
  output logic                                  out_valid,
  output wmpd_pkg::wheel_in_t                   wheel_o [wmpd_pkg::NUM_WHEELS]
);
  import wmpd_pkg::*;

  // stage 1
  logic                    v1_r;
  logic signed [VEL_W-1:0] vx_r, vy_r;
  logic signed [31:0]      w_r, w_nxt;
  logic signed [27:0]      px_r, px_nxt;
  logic signed [28:0]      py_r, py_nxt;
  logic [2:0]              mode_r;

  // stage 2
  logic                    v2_r;
  wheel_in_t               wheel_r   [NUM_WHEELS];
  wheel_in_t               wheel_nxt [NUM_WHEELS];

  logic signed [33:0] tx, ty, tyh, tpx, tpy, tw;
  logic signed [33:0] base [NUM_WHEELS];
  logic signed [33:0] sum  [NUM_WHEELS];
  logic signed [33:0] rnd  [NUM_WHEELS];
  logic [2:0]         used;

  always_comb begin
    w_nxt  = yaw_rate * $signed({1'b0, cfg.wheel_radius});
    px_nxt = vel_x * K_SQRT3_2;
    py_nxt = vel_y * K_ONE_P2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    vx_r   <= vel_x;
    vy_r   <= vel_y;
    w_r    <= w_nxt;
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    mode_r <= cfg.drive_mode;
  end

  // all terms at Q.24
  always_comb begin
    tx  = 34'(vx_r) <<< 12;
    ty  = 34'(vy_r) <<< 12;
    tyh = 34'(vy_r) <<< 11;
    tpx = 34'(px_r);
    tpy = 34'(py_r);
    tw  = 34'(w_r);
    for (int k = 0; k < NUM_WHEELS; k++) begin
      base[k] = '0;
    end
    used = 3'd0;
    case (mode_r)
      MODE_MECANUM: begin
        base[0] = tx + ty;
        base[1] = tx - ty;
        base[2] = -tx - ty;
        base[3] = ty - tx;
        used    = 3'd4;
      end
      MODE_OMNI3: begin
        base[0] = tpy;
        base[1] = tpx - tyh;
        base[2] = -tyh - tpx;
        used    = 3'd3;
      end
      MODE_OMNI4: begin
        base[0] = tx;
        base[1] = -ty;
        base[2] = -tx;
        base[3] = ty;
        used    = 3'd4;
      end
      MODE_SKID: begin
        base[0] = tx;
        base[1] = tx;
        base[2] = -tx;
        base[3] = -tx;
        used    = 3'd4;
      end
      MODE_DIFF: begin
        base[0] = tx;
        base[1] = -tx;
        used    = 3'd2;
      end
      default: begin
        used = 3'd0;
      end
    endcase
    for (int k = 0; k < NUM_WHEELS; k++) begin
      sum[k] = base[k] + tw;
      // round half up to Q.12
      rnd[k] = (sum[k] + 34'sd2048) >>> 12;
      wheel_nxt[k].spd  = rnd[k][SPD_W-1:0];
      wheel_nxt[k].stop = (3'(k) >= used) || (k >= WHEEL_COUNT);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_WHEELS; k++) begin
      wheel_r[k] <= wheel_nxt[k];
    end
  end

  assign out_valid = v2_r;
  always_comb begin
    for (int k = 0; k < NUM_WHEELS; k++) begin
      wheel_o[k] = wheel_r[k];
    end
  end

`ifndef NO_ASSERTIONS
  a_diff_stops_upper: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && mode_r == MODE_DIFF) |=> (wheel_r[2].stop && wheel_r[3].stop))
    else $error("two-wheel mode left an upper wheel running");

  a_omni3_stops_last: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && mode_r == MODE_OMNI3) |=> (wheel_r[3].stop && !wheel_r[0].stop))
    else $error("three-wheel mode wheel flags wrong");

  a_bad_mode_stops_all: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && mode_r != MODE_MECANUM && mode_r != MODE_OMNI3 && mode_r != MODE_OMNI4
     && mode_r != MODE_SKID && mode_r != MODE_DIFF) |=> wheel_r[0].stop)
    else $error("unknown drive mode did not stop wheel 0");
`endif

endmodule

// ===== src/wmpd_wheel.sv =====
// ----------------------------------------------------------------------------
// wmpd_wheel
// Per-wheel drive pipeline: clamp, reverse gain, round, duty product,
// then saturation, dead zone and direction.
// ----------------------------------------------------------------------------
module wmpd_wheel (
  input  logic                               clk,
  input  wmpd_pkg::wheel_in_t                wheel_i,
  input  wmpd_pkg::cfg_t                     cfg,
  output logic [wmpd_pkg::DUTY_BITS-1:0]     duty,
  output logic                               dir
);
  import wmpd_pkg::*;

  logic signed [SPD_W-1:0]  lim, nlim;
  logic signed [CLMP_W-1:0] c_r, c_nxt;
  logic                     stop1_r, stop2_r, stop3_r, stop4_r;
  logic signed [29:0]       prod_r, prod_nxt;
  logic signed [29:0]       prnd;
  logic signed [GAIN_W-1:0] s2_r, s2_nxt;
  logic signed [GAIN_W-1:0] dz, ndz;
  logic [MAG_W-1:0]         mag;
  logic [RAW_W-1:0]         raw_r, raw_nxt;
  logic                     pos_r, neg_r;
  logic [RAW_W-DUTY_SHIFT-1:0] hi;
  logic [DUTY_BITS-1:0]     d;
  logic [DUTY_BITS-1:0]     duty_r, duty_nxt;
  logic                     dir_r, dir_nxt;

  // clamp to +-max_speed
  always_comb begin
    lim  = $signed(SPD_W'(cfg.max_speed));
    nlim = -lim;
    if (wheel_i.spd > lim) begin
      c_nxt = lim[CLMP_W-1:0];
    end else if (wheel_i.spd < nlim) begin
      c_nxt = nlim[CLMP_W-1:0];
    end else begin
      c_nxt = wheel_i.spd[CLMP_W-1:0];
    end
  end

  // negative speeds take the reverse gain, positive ones pass at Q.24
  always_comb begin
    if (c_r < 0) begin
      prod_nxt = c_r * $signed({1'b0, cfg.reverse_gain});
    end else begin
      prod_nxt = 30'(c_r) <<< 12;
    end
    prnd   = (prod_r + 30'sd2048) >>> 12;
    s2_nxt = prnd[GAIN_W-1:0];
  end

  always_comb begin
    mag     = s2_r[GAIN_W-1] ? MAG_W'(-s2_r) : MAG_W'(s2_r);
    raw_nxt = RAW_W'(mag) * RAW_W'(cfg.duty_scale);
    dz      = $signed(GAIN_W'(cfg.dead_zone));
    ndz     = -dz;
  end

  always_comb begin
    hi = raw_r[RAW_W-1:DUTY_SHIFT];
    d  = (hi > (RAW_W-DUTY_SHIFT)'(DUTY_MAX)) ? DUTY_MAX : hi[DUTY_BITS-1:0];
    if (stop4_r) begin
      duty_nxt = DUTY_MAX;
      dir_nxt  = 1'b1;
    end else if (pos_r) begin
      duty_nxt = d;
      dir_nxt  = 1'b0;
    end else if (neg_r) begin
      duty_nxt = DUTY_MAX - d;
      dir_nxt  = 1'b1;
    end else begin
      duty_nxt = DUTY_MAX;
      dir_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    c_r     <= c_nxt;
    stop1_r <= wheel_i.stop;
    prod_r  <= prod_nxt;
    stop2_r <= stop1_r;
    s2_r    <= s2_nxt;
    stop3_r <= stop2_r;
    raw_r   <= raw_nxt;
    pos_r   <= s2_r > dz;
    neg_r   <= s2_r < ndz;
    stop4_r <= stop3_r;
    duty_r  <= duty_nxt;
    dir_r   <= dir_nxt;
  end

  assign duty = duty_r;
  assign dir  = dir_r;

endmodule

// ===== src/wheel_mixer_pwm_drive_core.sv =====
// An accepted command word runs through the mixer (2 stages) and the per-wheel drive pipeline (5 stages).
// Throughput: one command word per cycle; busy stays low, start may be high every cycle.
// Results carry no back-pressure: out_valid marks each word for exactly one cycle.
// Reset (rst_n, synchronous) clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
// wheel_mixer_pwm_drive_core
// Body velocity command to four-wheel PWM duty and direction, pipelined.
// ----------------------------------------------------------------------------
module wheel_mixer_pwm_drive_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [wmpd_pkg::VEL_W-1:0]      in_vel_x,
  input  logic signed [wmpd_pkg::VEL_W-1:0]      in_vel_y,
  input  logic signed [wmpd_pkg::VEL_W-1:0]      in_yaw_rate,
  output logic                                   out_valid,
  output logic [wmpd_pkg::DUTY_BITS-1:0]         out_duty_w0,
  output logic                                   out_dir_w0,
  output logic [wmpd_pkg::DUTY_BITS-1:0]         out_duty_w1,
  output logic                                   out_dir_w1,
  output logic [wmpd_pkg::DUTY_BITS-1:0]         out_duty_w2,
  output logic                                   out_dir_w2,
  output logic [wmpd_pkg::DUTY_BITS-1:0]         out_duty_w3,
  output logic                                   out_dir_w3,
  input  logic                                   cfg_we,
  input  logic [wmpd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [wmpd_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import wmpd_pkg::*;

  localparam int DRV_STAGES = 5;

  cfg_t                  cfg_r;
  logic                  accept;
  logic                  mix_valid;
  wheel_in_t             wheel [NUM_WHEELS];
  logic [DUTY_BITS-1:0]  duty [NUM_WHEELS];
  logic                  dir  [NUM_WHEELS];
  logic [DRV_STAGES-1:0] vpipe_r, vpipe_nxt;

  // the pipeline never stalls, so a word may enter every cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.drive_mode   <= MODE_MECANUM;
      cfg_r.max_speed    <= 15'd4096;
      cfg_r.duty_scale   <= 26'd65472;
      cfg_r.wheel_radius <= 15'd410;
      cfg_r.dead_zone    <= 15'd614;
      cfg_r.reverse_gain <= 13'd4506;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DRIVE_MODE:   cfg_r.drive_mode   <= cfg_data[2:0];
        REG_MAX_SPEED:    cfg_r.max_speed    <= cfg_data[14:0];
        REG_DUTY_SCALE:   cfg_r.duty_scale   <= cfg_data;
        REG_WHEEL_RADIUS: cfg_r.wheel_radius <= cfg_data[14:0];
        REG_DEAD_ZONE:    cfg_r.dead_zone    <= cfg_data[14:0];
        REG_REVERSE_GAIN: cfg_r.reverse_gain <= cfg_data[12:0];
        default: begin
        end
      endcase
    end
  end

  wmpd_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .vel_x     (in_vel_x),
    .vel_y     (in_vel_y),
    .yaw_rate  (in_yaw_rate),
    .cfg       (cfg_r),
    .out_valid (mix_valid),
    .wheel_o   (wheel)
  );

  for (genvar k = 0; k < NUM_WHEELS; k++) begin : g_wheel
    wmpd_wheel u_wheel (
      .clk     (clk),
      .wheel_i (wheel[k]),
      .cfg     (cfg_r),
      .duty    (duty[k]),
      .dir     (dir[k])
    );
  end

  // valid bits alongside the per-wheel stages
  assign vpipe_nxt = {vpipe_r[DRV_STAGES-2:0], mix_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vpipe_r <= '0;
    end else begin
      vpipe_r <= vpipe_nxt;
    end
  end

  assign out_valid   = vpipe_r[DRV_STAGES-1];
  assign out_duty_w0 = duty[0];
  assign out_dir_w0  = dir[0];
  assign out_duty_w1 = duty[1];
  assign out_dir_w1  = dir[1];
  assign out_duty_w2 = duty[2];
  assign out_dir_w2  = dir[2];
  assign out_duty_w3 = duty[3];
  assign out_dir_w3  = dir[3];

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##7 out_valid)
    else $error("accepted word did not come out after 7 cycles");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(mix_valid, 5))
    else $error("result word without a mixed word behind it");
`endif

endmodule
